// ===== hdl/gardner_symbol_timing_recovery_defines.svh =====
// Assertion macros shared by the timing recovery block
`ifndef GARDNER_SYMBOL_TIMING_RECOVERY_DEFINES_SVH
`define GARDNER_SYMBOL_TIMING_RECOVERY_DEFINES_SVH

// Check a condition at every clock edge outside reset
`define GSTR_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Check that a condition holds in the cycle after a trigger
`define GSTR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/gstr_pkg.sv =====
// Types, register indexes and helpers for the timing recovery block
package gstr_pkg;

	// complex sample: I in the low half, Q in the high half
	typedef logic [31:0] cplx_t;

	// window snapshot at a strobe, w0 is the newest sample
	typedef struct packed {
		cplx_t w3;
		cplx_t w2;
		cplx_t w1;
		cplx_t w0;
	} job_t;

	// loop result handed back to the front
	typedef struct packed {
		logic       valid;
		logic [1:0] step;
	} step_fb_t;

	localparam logic [1:0] REG_MODE = 2'd0;
	localparam logic [1:0] REG_KP   = 2'd1;
	localparam logic [1:0] REG_KI   = 2'd2;

	function automatic logic signed [15:0] re_of(input cplx_t p);
		re_of = p[15:0];
	endfunction

	function automatic logic signed [15:0] im_of(input cplx_t p);
		im_of = p[31:16];
	endfunction

endpackage

// ===== hdl/gstr_queue.sv =====
// Two-entry request queue between the sample front and the loop back end
module gstr_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  gstr_pkg::job_t  push_job,
	output logic            full,
	input  logic            pop,
	output logic            empty,
	output gstr_pkg::job_t  pop_job
);
	import gstr_pkg::*;

	job_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full    = (count_q == 2'd2);
	assign empty   = (count_q == 2'd0);
	assign pop_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop && !empty) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({push && !full, pop && !empty})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== hdl/gstr_front.sv =====
// Sample front: window shift, strobe countdown and request issue
module gstr_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [31:0]        s_tdata,   // sample_i [15:0], sample_q [31:16]
	input  logic               q_full,
	output logic               q_push,
	output gstr_pkg::job_t     q_job,
	input  gstr_pkg::step_fb_t fb,
	output logic               busy
);
	import gstr_pkg::*;

	// the incoming sample completes the four-deep window
	cplx_t      win_q [3];
	logic [1:0] cnt_q;
	logic       busy_q;
	logic       acc;

	assign busy     = busy_q;
	assign s_tready = !busy_q && !q_full;
	assign acc      = s_tvalid && s_tready;
	assign q_push   = acc && (cnt_q == 2'd0);
	assign q_job    = '{w3: win_q[2], w2: win_q[1], w1: win_q[0], w0: s_tdata};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				win_q[k] <= '0;
			end
			cnt_q  <= 2'd0;
			busy_q <= 1'b0;
		end else begin
			if (fb.valid) begin
				busy_q <= 1'b0;
				cnt_q  <= fb.step - 2'd1;
			end
			if (acc) begin
				win_q[2] <= win_q[1];
				win_q[1] <= win_q[0];
				win_q[0] <= s_tdata;
				// hold further samples until the loop returns the next step
				if (cnt_q != 2'd0) begin
					cnt_q <= cnt_q - 2'd1;
				end else begin
					busy_q <= 1'b1;
				end
			end
		end
	end

endmodule

// ===== hdl/gstr_back.sv =====
// Loop back end: interpolation, Gardner error, PI filter and result output
module gstr_back #(
	parameter int PHASE_BITS = 16,
	parameter int GAIN_BITS  = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  mode,
	input  logic [GAIN_BITS-1:0]  kp_gain,
	input  logic [GAIN_BITS-1:0]  ki_gain,
	input  logic                  q_empty,
	input  gstr_pkg::job_t        q_job,
	output logic                  q_pop,
	output gstr_pkg::step_fb_t    fb,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [31:0]           m_tdata,
	output logic                  m_tuser,
	output logic                  m_tlast
);
	import gstr_pkg::*;

	localparam int LW = PHASE_BITS + 19;
	localparam int MW = GAIN_BITS + 34;
	localparam int GP = GAIN_BITS + 18;
	localparam int SW = GP + 1;

	typedef enum logic [3:0] {
		ST_IDLE, ST_LERP, ST_ERR0, ST_ERR1, ST_KI, ST_INT, ST_KP, ST_LOOP, ST_OUT0, ST_OUT1
	} state_t;

	state_t                  state_q;
	job_t                    job_q;
	logic                    mode_q;
	logic [1:0]              k_q;
	cplx_t                   curr_q;
	cplx_t                   sec_q;
	cplx_t                   mid_q;
	cplx_t                   last_strobe_q;
	cplx_t                   last_mid_q;
	logic                    hv_q;
	logic signed [32:0]      prod_q;
	logic signed [34:0]      e_q;
	logic signed [GP-1:0]    gprod_q;
	logic signed [31:0]      integ_q;
	logic [PHASE_BITS-1:0]   mu_q;

	// shared interpolator, one component a cycle
	cplx_t                   l_c, r_c;
	logic signed [15:0]      lv, rv, lerp_c;
	logic signed [16:0]      d_c;
	logic signed [PHASE_BITS:0] mu_s;
	logic signed [PHASE_BITS+17:0] dm_c;
	logic signed [LW-1:0]    x_c, xb_c;

	always_comb begin
		if (!k_q[1]) begin
			l_c = job_q.w2;
			r_c = job_q.w1;
		end else if (mode_q) begin
			l_c = job_q.w1;
			r_c = job_q.w0;
		end else begin
			l_c = job_q.w3;
			r_c = job_q.w2;
		end
		lv   = k_q[0] ? im_of(l_c) : re_of(l_c);
		rv   = k_q[0] ? im_of(r_c) : re_of(r_c);
		d_c  = 17'(rv) - 17'(lv);
		mu_s = {1'b0, mu_q};
		dm_c = d_c * mu_s;
		x_c  = {{3{lv[15]}}, lv, {PHASE_BITS{1'b0}}} + {dm_c[PHASE_BITS+17], dm_c};
		// round toward zero
		xb_c = x_c + (x_c[LW-1] ? {{(LW-PHASE_BITS){1'b0}}, {PHASE_BITS{1'b1}}} : '0);
		lerp_c = xb_c[PHASE_BITS+15:PHASE_BITS];
	end

	// error terms
	cplx_t              mid_c;
	logic signed [16:0] dre_c, dim_c;
	logic signed [32:0] pim_c;

	assign mid_c = mode_q ? last_mid_q : sec_q;
	assign dre_c = 17'(re_of(curr_q)) - 17'(re_of(last_strobe_q));
	assign dim_c = 17'(im_of(curr_q)) - 17'(im_of(last_strobe_q));
	assign pim_c = im_of(mid_c) * dim_c;

	// shared gain multiplier on the error magnitude
	logic [GAIN_BITS-1:0] g_c;
	logic [33:0]          em_c;
	logic [MW-1:0]        gm_c;
	logic [GP-1:0]        gr_c;

	assign g_c  = (state_q == ST_KP) ? kp_gain : ki_gain;
	assign em_c = e_q[34] ? 34'(-e_q) : e_q[33:0];
	assign gm_c = g_c * em_c;
	assign gr_c = {1'b0, gm_c[MW-1:17]};

	// saturating sums
	logic signed [SW-1:0] isum_c;
	logic signed [31:0]   isat_c, v_c;
	logic signed [33:0]   pos_c;

	always_comb begin
		isum_c = {{(SW-32){integ_q[31]}}, integ_q} + {gprod_q[GP-1], gprod_q};
		if (&isum_c[SW-1:31] || ~|isum_c[SW-1:31]) begin
			isat_c = isum_c[31:0];
		end else begin
			isat_c = isum_c[SW-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end
		v_c = isat_c;
		pos_c = {3'b000, mu_q, {(31-PHASE_BITS){1'b0}}} + 34'sh1_0000_0000
			+ {{2{v_c[31]}}, v_c};
	end

	assign q_pop     = (state_q == ST_IDLE) && !q_empty;
	assign fb.valid  = (state_q == ST_LOOP);
	assign fb.step   = pos_c[32:31];
	assign m_tvalid  = (state_q == ST_OUT0) || (state_q == ST_OUT1);
	assign m_tdata   = (state_q == ST_OUT1) ? sec_q : curr_q;
	assign m_tuser   = (state_q == ST_OUT1);
	assign m_tlast   = (state_q == ST_OUT1) || !mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			k_q           <= 2'd0;
			mode_q        <= 1'b0;
			hv_q          <= 1'b0;
			integ_q       <= '0;
			mu_q          <= '0;
			last_strobe_q <= '0;
			last_mid_q    <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						mode_q  <= mode;
						k_q     <= 2'd0;
						state_q <= ST_LERP;
					end
				end
				ST_LERP: begin
					k_q <= k_q + 2'd1;
					if (k_q == 2'd3) begin
						state_q <= ST_ERR0;
					end
				end
				ST_ERR0: state_q <= ST_ERR1;
				ST_ERR1: state_q <= ST_KI;
				ST_KI:   state_q <= ST_INT;
				ST_INT: begin
					integ_q <= isat_c;
					state_q <= ST_KP;
				end
				ST_KP:   state_q <= ST_LOOP;
				ST_LOOP: begin
					mu_q          <= pos_c[30:31-PHASE_BITS];
					last_strobe_q <= curr_q;
					last_mid_q    <= mode_q ? sec_q : mid_q;
					hv_q          <= 1'b1;
					state_q       <= ST_OUT0;
				end
				ST_OUT0: begin
					if (m_tready) begin
						state_q <= mode_q ? ST_OUT1 : ST_IDLE;
					end
				end
				ST_OUT1: begin
					if (m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_q <= q_job;
		end
		if (state_q == ST_LERP) begin
			unique case (k_q)
				2'd0: curr_q[15:0]  <= lerp_c;
				2'd1: curr_q[31:16] <= lerp_c;
				2'd2: sec_q[15:0]   <= lerp_c;
				2'd3: sec_q[31:16]  <= lerp_c;
				default: sec_q      <= sec_q;
			endcase
		end
		if (state_q == ST_ERR0) begin
			prod_q <= re_of(mid_c) * dre_c;
		end
		if (state_q == ST_ERR1) begin
			mid_q <= mid_c;
			e_q   <= hv_q ? (35'(prod_q) + 35'(pim_c)) : '0;
		end
		if (state_q == ST_KI || state_q == ST_KP) begin
			gprod_q <= e_q[34] ? -$signed(gr_c) : $signed(gr_c);
		end
		if (state_q == ST_LOOP) begin
			gprod_q <= '0;
		end
	end

endmodule

// ===== hdl/gardner_symbol_timing_recovery.sv =====
// Gardner symbol timing recovery with PI loop, top level.
// A sample that does not strobe is taken without holding the input. A strobing sample
// holds the input while the shared interpolator and gain multiplier step through the loop.
// Mode 1 gives two results per strobe, one per cycle while the sink is ready.
// Reset (arst_n low) clears window, phase, integrator and history, and loads the default mode and gains.
`include "gardner_symbol_timing_recovery_defines.svh"
module gardner_symbol_timing_recovery #(
	parameter int PHASE_BITS = 16,
	parameter int GAIN_BITS  = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [31:0]          s_tdata,   // sample_i [15:0], sample_q [31:16]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [31:0]          m_tdata,   // out_i [15:0], out_q [31:16]
	output logic                 m_tuser,   // half_slot [0]
	output logic                 m_tlast,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [1:0]           cfg_index,
	input  logic [GAIN_BITS-1:0] cfg_data
);
	import gstr_pkg::*;

	logic                 mode_q;
	logic [GAIN_BITS-1:0] kp_q;
	logic [GAIN_BITS-1:0] ki_q;
	logic                 q_push, q_full, q_pop, q_empty, busy;
	job_t                 push_job, pop_job;
	step_fb_t             fb;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			kp_q   <= GAIN_BITS'(1548112);
			ki_q   <= GAIN_BITS'(5348);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_MODE: mode_q <= cfg_data[0];
				REG_KP:   kp_q   <= cfg_data;
				REG_KI:   ki_q   <= cfg_data;
				default:  mode_q <= mode_q;
			endcase
		end
	end

	gstr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_job    (push_job),
		.fb       (fb),
		.busy     (busy)
	);

	gstr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (q_pop),
		.empty    (q_empty),
		.pop_job  (pop_job)
	);

	gstr_back #(
		.PHASE_BITS (PHASE_BITS),
		.GAIN_BITS  (GAIN_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.mode     (mode_q),
		.kp_gain  (kp_q),
		.ki_gain  (ki_q),
		.q_empty  (q_empty),
		.q_job    (pop_job),
		.q_pop    (q_pop),
		.fb       (fb),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	`GSTR_ASSERT(a_half_is_last, !(m_tvalid && m_tuser) || m_tlast, "half-slot result not last")
	`GSTR_ASSERT(a_queue_no_overflow, !(q_push && q_full), "request pushed into full queue")
	`GSTR_ASSERT_NEXT(a_strobe_blocks, q_push, busy && !s_tready, "input open during loop update")

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the Gardner timing recovery block, with a streaming driver and monitor
`timescale 1ns / 1ps
module tb;
	import gstr_pkg::*;

	localparam logic [1:0] REG_SPARE = 2'd3;
	localparam logic HALF_STROBE = 1'b0;
	localparam logic HALF_MID    = 1'b1;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int LONG_HOLD     = 300;

	typedef struct packed {
		logic [31:0] data;
		logic        half;
		logic        last;
	} sym_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [31:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic m_tuser;
	logic m_tlast;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [23:0] cfg_data = '0;

	gardner_symbol_timing_recovery DUT (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// timing loop state as the block should hold it
	logic [31:0] win [4];
	logic [15:0] mu;
	logic signed [31:0] integ;
	logic [31:0] strobe_hist, mid_hist;
	logic hist_ok;
	int unsigned wait_samples;
	logic cur_mode;
	logic [23:0] kp, ki;

	logic [31:0] sample_queue [$];
	sym_t symbol_queue [$];
	int errors = 0, n_samples = 0, n_symbols = 0, n_strobes = 0, n_cfg = 0;
	bit sender_quiet = 0, receiver_quiet = 0, hold_done = 0;

	function automatic logic [15:0] interp_part(logic signed [15:0] l, logic signed [15:0] r,
			logic [15:0] frac);
		longint x, q;
		x = longint'(l) * 65536 + (longint'(r) - longint'(l)) * longint'(frac);
		q = (x >= 0) ? (x >>> 16) : -((-x) >>> 16);
		return q[15:0];
	endfunction

	function automatic logic [31:0] interp(logic [31:0] l, logic [31:0] r, logic [15:0] frac);
		return {interp_part(l[31:16], r[31:16], frac), interp_part(l[15:0], r[15:0], frac)};
	endfunction

	function automatic longint gain_scale(logic [23:0] g, longint e);
		longint m;
		m = (e < 0) ? -e : e;
		m = (longint'(g) * m) >>> 17;
		return (e < 0) ? -m : m;
	endfunction

	function automatic logic signed [31:0] clip32(longint x);
		if (x > 64'sd2147483647) return 32'sh7fffffff;
		if (x < -64'sd2147483648) return 32'sh80000000;
		return x[31:0];
	endfunction

	task automatic predict_symbols(logic [31:0] smp);
		logic [31:0] curr, mid, slot1;
		longint e, p;
		logic signed [31:0] v;
		win[3] = win[2]; win[2] = win[1]; win[1] = win[0]; win[0] = smp;
		if (wait_samples != 0) begin
			wait_samples--;
			return;
		end
		n_strobes++;
		curr = interp(win[2], win[1], mu);
		slot1 = interp(win[1], win[0], mu);
		mid = cur_mode ? mid_hist : interp(win[3], win[2], mu);
		e = 0;
		if (hist_ok)
			e = longint'($signed(mid[15:0])) * (longint'($signed(curr[15:0]))
				- longint'($signed(strobe_hist[15:0])))
				+ longint'($signed(mid[31:16])) * (longint'($signed(curr[31:16]))
				- longint'($signed(strobe_hist[31:16])));
		integ = clip32(longint'(integ) + gain_scale(ki, e));
		v = clip32(gain_scale(kp, e) + longint'(integ));
		p = (longint'(mu) <<< 15) + (64'sd2 <<< 31) + longint'(v);
		wait_samples = int'(p >>> 31) - 1;
		mu = p[30:15];
		strobe_hist = curr;
		mid_hist = cur_mode ? slot1 : mid;
		hist_ok = 1'b1;
		if (!cur_mode) begin
			symbol_queue.push_back('{curr, HALF_STROBE, 1'b1});
		end else begin
			symbol_queue.push_back('{curr, HALF_STROBE, 1'b0});
			symbol_queue.push_back('{slot1, HALF_MID, 1'b1});
		end
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// sample driver
	int send_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				predict_symbols(sample_queue.pop_front());
				n_samples++;
			end
			if (!s_tvalid || s_tready) begin
				if (send_gap > 0) begin
					send_gap--;
					s_tvalid <= 1'b0;
				end else if (sample_queue.size() != 0) begin
					s_tvalid <= 1'b1;
					s_tdata <= sample_queue[0];
					send_gap = sender_quiet ? 0 : pick_gap();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	int recv_gap = 0, hold_left = 0;
	always @(posedge clk or negedge arst_n) begin
		sym_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				n_symbols++;
				if (symbol_queue.size() == 0) begin
					$error("unexpected result %h half %b last %b", m_tdata, m_tuser, m_tlast);
					errors++;
				end else begin
					want = symbol_queue.pop_front();
					if (m_tdata[15:0] !== want.data[15:0]) begin
						$error("out_i expected %h actual %h", want.data[15:0], m_tdata[15:0]);
						errors++;
					end
					if (m_tdata[31:16] !== want.data[31:16]) begin
						$error("out_q expected %h actual %h", want.data[31:16], m_tdata[31:16]);
						errors++;
					end
					if (m_tuser !== want.half) begin
						$error("half_slot expected %b actual %b", want.half, m_tuser);
						errors++;
					end
					if (m_tlast !== want.last) begin
						$error("last expected %b actual %b", want.last, m_tlast);
						errors++;
					end
				end
			end
			// hold off once for a long stretch so the block backs up
			if (!hold_done && n_samples >= 500) begin
				hold_done = 1;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				recv_gap = receiver_quiet ? 0 : pick_gap();
			end
		end
	end

	int cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("gardner_symbol_timing_recovery test failed");
			$finish;
		end
	end

	task automatic drain();
		while (sample_queue.size() != 0 || s_tvalid || symbol_queue.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// leaves cfg_valid high; the caller drops it after the last write
	task automatic write_reg(logic [1:0] idx, logic [23:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		n_cfg++;
		case (idx)
			REG_MODE: cur_mode = val[0];
			REG_KP:   kp = val;
			REG_KI:   ki = val;
			default: ;
		endcase
	endtask

	task automatic setup(logic md, logic [23:0] kpv, logic [23:0] kiv);
		drain();
		@(posedge clk);
		write_reg(REG_MODE, {23'd0, md});
		write_reg(REG_KP, kpv);
		write_reg(REG_KI, kiv);
		write_reg(REG_SPARE, 24'($urandom()));
		cfg_valid <= 1'b0;
	endtask

	// mostly a noisy two-level symbol stream at two samples per symbol, some raw noise
	task automatic queue_stream(int count);
		int amp, sym_i, sym_q, last_i, last_q, ni, nq;
		amp = $urandom_range(1000, 32000);
		last_i = 0;
		last_q = 0;
		for (int k = 0; k < count; k += 2) begin
			if ($urandom_range(0, 9) < 2) begin
				sample_queue.push_back($urandom());
				sample_queue.push_back($urandom());
			end else begin
				sym_i = $urandom_range(0, 1) ? amp : -amp;
				sym_q = $urandom_range(0, 1) ? amp : -amp;
				ni = $signed($urandom_range(0, 1000)) - 500;
				nq = $signed($urandom_range(0, 1000)) - 500;
				sample_queue.push_back({16'((last_q + sym_q) / 2 + nq),
					16'((last_i + sym_i) / 2 + ni)});
				sample_queue.push_back({16'(sym_q), 16'(sym_i)});
				last_i = sym_i;
				last_q = sym_q;
			end
		end
	endtask

	initial begin
		for (int k = 0; k < 4; k++) win[k] = '0;
		mu = '0; integ = '0; strobe_hist = '0; mid_hist = '0; hist_ok = 1'b0;
		wait_samples = 0; cur_mode = 1'b0; kp = 24'd1548112; ki = 24'd5348;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// extremes with the reset gains, both modes
		sample_queue.push_back({16'h7fff, 16'h7fff});
		sample_queue.push_back({16'h8000, 16'h8000});
		sample_queue.push_back({16'h7fff, 16'h8000});
		sample_queue.push_back({16'h8000, 16'h7fff});
		sample_queue.push_back(32'h0);
		sample_queue.push_back(32'hffff_ffff);
		sample_queue.push_back({16'h8000, 16'h8000});
		sample_queue.push_back({16'h7fff, 16'h7fff});
		sample_queue.push_back(32'h5555_aaaa);
		sample_queue.push_back(32'haaaa_5555);
		setup(1'b1, 24'd1548112, 24'd5348);
		for (int k = 0; k < 10; k++)
			sample_queue.push_back((k % 2) ? {16'h8000, 16'h7fff} : {16'h7fff, 16'h8000});
		// maximum gains drive the loop into its step limits
		setup(1'b0, 24'hffffff, 24'hffffff);
		queue_stream(150);
		setup(1'b1, 24'hffffff, 24'hffffff);
		queue_stream(150);
		setup(1'b0, 24'd0, 24'd0);
		sender_quiet = 1;
		receiver_quiet = 1;
		queue_stream(100);
		setup(1'b1, 24'd1548112, 24'd5348);
		sender_quiet = 0;
		receiver_quiet = 0;
		queue_stream(350);
		for (int ph = 0; ph < 4; ph++) begin
			setup(ph[0], 24'($urandom_range(0, 24'hffffff)),
				24'($urandom_range(0, 24'h3ffff)));
			queue_stream(76);
		end
		drain();
		$display("%0d samples, %0d strobes, %0d results checked, %0d register writes",
			n_samples, n_strobes, n_symbols, n_cfg);
		$display("covered both modes, zero and full-scale gains and a long output stall");
		if (errors == 0)
			$display("gardner_symbol_timing_recovery test passed");
		else
			$display("gardner_symbol_timing_recovery test failed");
		$finish;
	end
endmodule
